// File: sv/mss_pkg.sv
// ----------------------------------------------------------------------------
// Multiway sorted search: shared package
// Sizes, command format and state encoding used by the front, the back and
// the top level of the multiway sorted search core.
// ----------------------------------------------------------------------------
package mss_pkg;

    // Store size and number of probes per narrowing round.
    localparam int DEPTH  = 1024;
    localparam int PROBES = 8;

    // Fixed field widths.
    localparam int LEN_W = 11;
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int POS_W = 10;

    // Derived widths.
    localparam int AW  = $clog2(DEPTH);
    localparam int NW  = $clog2(DEPTH + 1);
    localparam int PW  = (PROBES > 1) ? $clog2(PROBES) : 1;
    localparam int DIV = PROBES + 1;

    // Probe numerator width: holds span * PROBES + PROBES at most.
    localparam int XW = $clog2(longint'(DEPTH) * longint'(PROBES) + 64'd1);

    // Truncated reciprocal of DIV; the quotient estimate is low by at most one.
    localparam longint unsigned RECIP = (longint'(1) << XW) / DIV;

    // Depth of the command queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Operation codes of an input beat.
    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                    is_search;
        logic                    store_ok;
        logic [AW-1:0]           addr;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_MUL,
        ST_ADDR,
        ST_CMP,
        ST_SREAD,
        ST_SCMP,
        ST_DONE
    } t_state;

endpackage

// File: sv/mss_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/mss_front.sv
// ----------------------------------------------------------------------------
// Multiway sorted search: front end
// Accepts input beats, decodes them into commands and holds them in a short
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module mss_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_op,
    input  logic [mss_pkg::IDX_W-1:0]        i_index,
    input  logic signed [mss_pkg::VAL_W-1:0] i_value,
    output mss_pkg::t_cmd                    o_cmd,
    output logic                             o_cmd_valid,
    input  logic                             i_cmd_pop
);
    import mss_pkg::*;

    t_cmd             r_queue [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QCW-1:0]   r_count;
    logic [QAW-1:0]   n_wp;
    logic [QAW-1:0]   n_rp;
    logic [QCW-1:0]   n_count;
    t_cmd             w_cmd;
    logic             w_push;

    // Decode the beat; a store beyond the store depth is dropped later.
    always_comb begin
        w_cmd.is_search = (i_op == OP_SEARCH);
        w_cmd.store_ok  = (32'(i_index) < 32'(DEPTH));
        w_cmd.addr      = AW'(i_index);
        w_cmd.value     = i_value;
    end

    assign o_in_ready  = (r_count != QCW'(QDEPTH));
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rp];

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (w_push) begin
            n_wp = (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + QAW'(1);
        end
        if (i_cmd_pop) begin
            n_rp = (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + QAW'(1);
        end
        if (w_push && !i_cmd_pop) begin
            n_count = r_count + QCW'(1);
        end else if (!w_push && i_cmd_pop) begin
            n_count = r_count - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wp] <= w_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("command queue holds more than its depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> (r_count != '0))
        else $error("command popped from an empty queue");
`endif

endmodule

// File: sv/mss_back.sv
// ----------------------------------------------------------------------------
// Multiway sorted search: back end
// Executes queued commands against the element store: writes stores, runs
// the probe rounds and the final scan of a search, and holds the result
// in an output register.
// ----------------------------------------------------------------------------
module mss_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mss_pkg::t_cmd             i_cmd,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_pop,
    input  logic [mss_pkg::LEN_W-1:0] i_length,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_found,
    output logic [mss_pkg::POS_W-1:0] o_position
);
    import mss_pkg::*;

    t_state                  r_state, n_state;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic [AW-1:0]           r_lo, n_lo;
    logic [AW-1:0]           r_hi, n_hi;
    logic [AW-1:0]           r_span, n_span;
    logic [AW-1:0]           r_prev, n_prev;
    logic [AW-1:0]           r_m, n_m;
    logic [AW-1:0]           r_k, n_k;
    logic [PW-1:0]           r_pidx, n_pidx;
    logic [XW-1:0]           r_acc, n_acc;
    logic [2*XW-1:0]         r_prod;
    logic                    r_found, n_found;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_found, n_out_found;
    logic [POS_W-1:0]        r_out_pos, n_out_pos;

    logic [NW-1:0]           w_n;
    logic [XW-1:0]           w_q_est;
    logic [XW-1:0]           w_qd;
    logic [XW-1:0]           w_rem;
    logic [XW-1:0]           w_q;
    logic [AW-1:0]           w_m;
    logic                    w_we;
    logic [AW-1:0]           w_raddr;
    logic [VAL_W-1:0]        w_rdata;

    mss_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_cmd.addr),
        .i_wdata (i_cmd.value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Length in use, limited to the store depth.
    assign w_n = (32'(i_length) > 32'(DEPTH)) ? NW'(DEPTH) : NW'(i_length);

    // Probe offset = floor(acc / DIV) by reciprocal multiply plus one correction.
    assign w_q_est = r_prod[2*XW-1:XW];
    assign w_qd    = XW'((2*XW)'(w_q_est) * (2*XW)'(DIV));
    assign w_rem   = r_acc - w_qd;
    assign w_q     = (w_rem >= XW'(DIV)) ? w_q_est + XW'(1) : w_q_est;
    assign w_m     = r_lo + AW'(w_q);

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_span      = r_span;
        n_prev      = r_prev;
        n_m         = r_m;
        n_k         = r_k;
        n_pidx      = r_pidx;
        n_acc       = r_acc;
        n_found     = r_found;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_pos   = r_out_pos;
        o_cmd_pop   = 1'b0;
        w_we        = 1'b0;
        w_raddr     = r_k;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.is_search) begin
                        n_key = i_cmd.value;
                        if (w_n == '0) begin
                            n_found = 1'b0;
                            n_pos   = '0;
                            n_state = ST_DONE;
                        end else begin
                            n_lo    = '0;
                            n_hi    = AW'(w_n - NW'(1));
                            n_state = ST_ROUND;
                        end
                    end else begin
                        w_we = i_cmd.store_ok;
                    end
                end
            end
            ST_ROUND: begin
                if (32'(r_hi - r_lo) > 32'(PROBES)) begin
                    n_span  = r_hi - r_lo;
                    n_acc   = XW'(PROBES);
                    n_pidx  = '0;
                    n_prev  = r_lo;
                    n_state = ST_MUL;
                end else begin
                    n_k     = r_lo;
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_state = ST_SREAD;
                end
            end
            ST_MUL: begin
                n_state = ST_ADDR;
            end
            ST_ADDR: begin
                w_raddr = w_m;
                n_m     = w_m;
                n_acc   = r_acc + XW'(r_span);
                n_state = ST_CMP;
            end
            ST_CMP: begin
                priority if (!($signed(w_rdata) < r_key)) begin
                    // First probe not below the key closes the interval.
                    if (r_pidx != '0) begin
                        n_lo = r_prev + AW'(1);
                    end
                    n_hi    = r_m;
                    n_state = ST_ROUND;
                end else if (r_pidx == PW'(PROBES - 1)) begin
                    n_lo    = r_m + AW'(1);
                    n_state = ST_ROUND;
                end else begin
                    n_prev  = r_m;
                    n_pidx  = r_pidx + PW'(1);
                    n_state = ST_ADDR;
                end
            end
            ST_SREAD: begin
                w_raddr = r_k;
                n_state = ST_SCMP;
            end
            ST_SCMP: begin
                priority if ($signed(w_rdata) == r_key) begin
                    n_found = 1'b1;
                    n_pos   = POS_W'(r_k);
                    n_state = ST_DONE;
                end else if (r_k == r_hi) begin
                    n_state = ST_DONE;
                end else begin
                    n_k     = r_k + AW'(1);
                    n_state = ST_SREAD;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_pos   = r_pos;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_span      <= n_span;
        r_prev      <= n_prev;
        r_m         <= n_m;
        r_k         <= n_k;
        r_pidx      <= n_pidx;
        r_acc       <= n_acc;
        r_prod      <= (2*XW)'(r_acc) * (2*XW)'(RECIP);
        r_found     <= n_found;
        r_pos       <= n_pos;
        r_out_found <= n_out_found;
        r_out_pos   <= n_out_pos;
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_position  = r_out_pos;

`ifndef SYNTHESIS
    a_probe_in_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADDR) |-> (w_m >= r_lo && w_m <= r_hi))
        else $error("probe address outside the search interval");

    a_quotient_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADDR) |-> ((XW+2)'(w_rem) < (XW+2)'(2 * DIV)))
        else $error("reciprocal quotient estimate off by more than one");

    a_scan_in_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCMP) |-> (r_k >= r_lo && r_k <= r_hi))
        else $error("scan index outside the search interval");

    a_miss_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_pos == '0))
        else $error("miss reported with a nonzero position");
`endif

endmodule

// File: sv/multiway_sorted_search_core.sv
// ----------------------------------------------------------------------------
// Multiway sorted search core
// Element store with a multiway (p-ary) search over its sorted prefix.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): a beat with i_op = 0 writes i_value
// into the store at i_index and gives no result; a beat with i_op = 1 searches
// for i_value among entries 0 .. length-1, which must be sorted ascending.
// Output channel (o_out_valid / i_out_ready): one beat per search with o_found
// and the lowest matching o_position (zero on a miss).
// Configuration channel (i_cfg_valid / o_cfg_ready): writes the length in use;
// write it only while no search is pending. It is always ready.
// Beats enter a two-entry command queue, so input is taken while the back end
// searches or a result waits. A store is written as the back end takes it.
// A search runs narrowing rounds of up to 8 probes, then scans at most 9
// entries; each probe and each scanned entry is a read through the single
// read port of the store. At a length of 1024 a search takes up to four
// rounds, and its result is registered in the output register from ST_DONE.
// One search runs at a time. Reset clears the queue, the output valid flag
// and the length; the store contents are undefined until written. A stalled
// receiver holds the result in the output register; the back end waits once
// its next search is done, and the queue fills.
// ----------------------------------------------------------------------------
module multiway_sorted_search_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_op,
    input  logic [mss_pkg::IDX_W-1:0]        i_index,
    input  logic signed [mss_pkg::VAL_W-1:0] i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_found,
    output logic [mss_pkg::POS_W-1:0]        o_position,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mss_pkg::LEN_W-1:0]        i_cfg_length_in_use
);
    import mss_pkg::*;

    logic [LEN_W-1:0] r_length;
    t_cmd             w_cmd;
    logic             w_cmd_valid;
    logic             w_cmd_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_length <= i_cfg_length_in_use;
        end
    end

    mss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    mss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_length    (r_length),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_found     (o_found),
        .o_position  (o_position)
    );

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multiway sorted search core: testbench
// Loads sorted element lists through the input channel, sets the length in
// use through the configuration channel, and checks every search beat against
// a predictor that repeats the narrowing rounds and the final scan over its
// own copy of the store. Stimulus runs under several idling mixes, with one
// long receiver hold-off that fills the block's command queue.
// ----------------------------------------------------------------------------
module tb;
    import mss_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int QUIET_CYCLES = 16;
    localparam int TAIL_CYCLES  = 100;

    localparam logic signed [VAL_W-1:0] ELEM_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] ELEM_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_search_outcome;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    in_valid   = 1'b0;
    logic                    in_op      = OP_STORE;
    logic [IDX_W-1:0]        in_index   = '0;
    logic signed [VAL_W-1:0] in_value   = '0;
    logic                    out_ready  = 1'b0;
    logic                    cfg_valid  = 1'b0;
    logic [LEN_W-1:0]        cfg_length = '0;
    logic                    in_ready;
    logic                    out_valid;
    logic                    found;
    logic [POS_W-1:0]        position;
    logic                    cfg_ready;

    // Predictor state: a copy of the store and of the length register.
    logic signed [VAL_W-1:0] element_copy [DEPTH];
    logic [LEN_W-1:0]        length_copy = '0;
    t_search_outcome         awaited_outcomes [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int error_count    = 0;
    int store_count    = 0;
    int search_count   = 0;
    int hit_count      = 0;
    int length_writes  = 0;

    multiway_sorted_search_core i_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_op                (in_op),
        .i_index             (in_index),
        .i_value             (in_value),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_found             (found),
        .o_position          (position),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_length_in_use (cfg_length)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Narrowing rounds of evenly spaced probes, then a scan of what is left.
    function automatic t_search_outcome predict_search(input logic signed [VAL_W-1:0] key);
        t_search_outcome outcome;
        longint          span_lo;
        longint          span_hi;
        longint          span;
        longint          probe_at;
        longint          last_below;
        longint          first_not_below;
        longint          k;
        int              used;
        int              hit_probe;
        int              p;
        outcome.found    = 1'b0;
        outcome.position = '0;
        used = (length_copy > DEPTH) ? DEPTH : int'(length_copy);
        if (used == 0)
            return outcome;
        span_lo = 0;
        span_hi = used - 1;
        while (span_hi - span_lo > PROBES) begin
            span            = span_hi - span_lo;
            hit_probe       = PROBES;
            last_below      = span_lo;
            first_not_below = span_lo;
            for (p = 0; p < PROBES && hit_probe == PROBES; p++) begin
                probe_at = span_lo + (span * p + PROBES) / (PROBES + 1);
                if (!(element_copy[probe_at] < key)) begin
                    hit_probe       = p;
                    first_not_below = probe_at;
                end else begin
                    last_below = probe_at;
                end
            end
            if (hit_probe == 0) begin
                span_hi = first_not_below;
            end else if (hit_probe == PROBES) begin
                span_lo = last_below + 1;
            end else begin
                span_lo = last_below + 1;
                span_hi = first_not_below;
            end
        end
        for (k = span_lo; k <= span_hi && !outcome.found; k++) begin
            if (element_copy[k] == key) begin
                outcome.found    = 1'b1;
                outcome.position = k[POS_W-1:0];
            end
        end
        return outcome;
    endfunction

    function automatic longint unsigned rand_below(input longint unsigned bound);
        return {$urandom, $urandom} % bound;
    endfunction

    // Offers one input beat, waits for it to be taken and updates the predictor.
    task automatic offer_beat(input logic op, input logic [IDX_W-1:0] idx,
                              input logic signed [VAL_W-1:0] val);
        t_search_outcome outcome;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_index <= idx;
        in_value <= val;
        do @(posedge clk); while (!in_ready);
        if (op == OP_STORE) begin
            element_copy[idx] = val;
            store_count++;
        end else begin
            outcome = predict_search(val);
            awaited_outcomes.push_back(outcome);
            search_count++;
            if (outcome.found)
                hit_count++;
        end
    endtask

    // Stops offering beats until every search has answered and trailing
    // stores have left the queue.
    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        cfg_valid  <= 1'b1;
        cfg_length <= len;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        length_copy  = len;
        length_writes++;
    endtask

    // Receiver side: random stalls, or a counted hold-off when one is requested.
    always @(posedge clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        t_search_outcome want;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_outcomes.size() == 0) begin
                $error("result beat arrived with no search pending");
                error_count++;
            end else begin
                want = awaited_outcomes.pop_front();
                if (found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, found);
                    error_count++;
                end
                if (position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, position);
                    error_count++;
                end
            end
        end
    end

    // The limit stops a hung run; it is set to hold even when every beat is a
    // full-length search under heavy stalls.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_outcomes.size());
            $display("multiway_sorted_search_core verification failed");
            $finish;
        end
    end

    // With a length of zero nothing is read, so this runs on the empty store.
    task automatic test_empty_store();
        offer_beat(OP_SEARCH, '0, ELEM_MIN);
        offer_beat(OP_SEARCH, '1, ELEM_MAX);
        offer_beat(OP_SEARCH, 10'h155, 32'sd0);
        wait_for_quiet();
    endtask

    // A short list with duplicates and both value extremes; a length of nine
    // goes straight to the scan, ten takes one narrowing round first.
    task automatic test_short_lists();
        logic signed [VAL_W-1:0] short_list [10];
        int i;
        short_list = '{ELEM_MIN, ELEM_MIN, -32'sd5, 32'sd0, 32'sd0, 32'sd0, 32'sd7,
                       32'sd100, ELEM_MAX - 1, ELEM_MAX};
        for (i = 0; i < 10; i++)
            offer_beat(OP_STORE, i[IDX_W-1:0], short_list[i]);
        offer_beat(OP_STORE, '1, ELEM_MAX);
        wait_for_quiet();
        write_length(11'd9);
        offer_beat(OP_SEARCH, 10'h2aa, ELEM_MIN);
        offer_beat(OP_SEARCH, '0, 32'sd0);
        offer_beat(OP_SEARCH, '1, ELEM_MAX);
        offer_beat(OP_SEARCH, '0, 32'sd1);
        wait_for_quiet();
        write_length(11'd10);
        offer_beat(OP_SEARCH, '0, ELEM_MAX);
        offer_beat(OP_SEARCH, '0, ELEM_MAX - 1);
        offer_beat(OP_SEARCH, '0, 32'sd100);
        offer_beat(OP_SEARCH, '0, -32'sd5);
        offer_beat(OP_SEARCH, '0, -32'sd6);
        wait_for_quiet();
    endtask

    // Writes every entry with a random ascending walk from the lowest to the
    // highest value, with runs of equal entries along the way, then searches it.
    task automatic test_full_store();
        longint walk;
        int     i;
        walk = longint'(ELEM_MIN);
        for (i = 0; i < DEPTH; i++) begin
            if (i == DEPTH - 1) begin
                walk = longint'(ELEM_MAX);
            end else if (i > 0 && $urandom_range(4) != 0) begin
                walk = walk + longint'(rand_below(
                           2 * (longint'(ELEM_MAX) - walk) / (DEPTH - 1 - i) + 1));
                if (walk > longint'(ELEM_MAX))
                    walk = longint'(ELEM_MAX);
            end
            offer_beat(OP_STORE, i[IDX_W-1:0], 32'(walk));
        end
        wait_for_quiet();
        write_length(11'd1024);
        offer_beat(OP_SEARCH, '0, ELEM_MIN);
        offer_beat(OP_SEARCH, '0, ELEM_MAX);
        offer_beat(OP_SEARCH, '0, element_copy[512]);
        offer_beat(OP_SEARCH, '0, element_copy[700] + 1);
        wait_for_quiet();
    endtask

    // Breaks the ordering at a few places, searches, then puts the old
    // entries back so that later traffic sees a sorted store again.
    task automatic test_unsorted_store();
        int                      slot  [8];
        logic signed [VAL_W-1:0] saved [8];
        logic signed [VAL_W-1:0] wild  [8];
        int                      j;
        for (j = 0; j < 8; j++) begin
            slot[j]  = $urandom_range(DEPTH - 1);
            saved[j] = element_copy[slot[j]];
            wild[j]  = $urandom;
            offer_beat(OP_STORE, slot[j][IDX_W-1:0], wild[j]);
        end
        for (j = 0; j < 12; j++)
            offer_beat(OP_SEARCH, IDX_W'($urandom_range(DEPTH - 1)),
                       (j < 8) ? wild[j] : element_copy[$urandom_range(DEPTH - 1)]);
        for (j = 7; j >= 0; j--)
            offer_beat(OP_STORE, slot[j][IDX_W-1:0], saved[j]);
        wait_for_quiet();
    endtask

    // The receiver holds off while full-length searches keep coming, so the
    // queue fills and input stalls; then the sender waits for every result.
    task automatic test_backpressure();
        int j;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 400;
        for (j = 0; j < 12; j++)
            offer_beat(OP_SEARCH, '0, element_copy[$urandom_range(DEPTH - 1)]);
        wait_for_quiet();
    endtask

    task automatic test_random_traffic();
        logic [LEN_W-1:0]        length_plan [16];
        logic signed [VAL_W-1:0] key;
        longint                  below;
        longint                  above;
        int                      used;
        int                      slot;
        int                      phase;
        int                      plan_slot;
        int                      beat;
        int                      pick;
        length_plan = '{11'd1024, 11'd2, 11'd9, 11'd10, 11'd17, 11'd0, 11'd100, 11'd1023,
                        11'd2047, 11'd513, 11'd1, 11'd1025, 11'd64, 11'd700, 11'd1024,
                        11'd333};
        plan_slot = 0;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            repeat (4) begin
                wait_for_quiet();
                write_length(length_plan[plan_slot]);
                plan_slot++;
                used = (length_copy > DEPTH) ? DEPTH : int'(length_copy);
                for (beat = 0; beat < 56; beat++) begin
                    if ($urandom_range(99) < 20) begin
                        // Stores keep the ordering: the new value lies between
                        // its neighbors.
                        slot  = $urandom_range(DEPTH - 1);
                        below = (slot > 0) ? longint'(element_copy[slot - 1])
                                           : longint'(ELEM_MIN);
                        above = (slot < DEPTH - 1) ? longint'(element_copy[slot + 1])
                                                   : longint'(ELEM_MAX);
                        offer_beat(OP_STORE, slot[IDX_W-1:0],
                                   32'(below + longint'(rand_below(above - below + 1))));
                    end else begin
                        pick = $urandom_range(99);
                        if (used > 0 && pick < 55)
                            key = element_copy[$urandom_range(used - 1)];
                        else if (used > 0 && pick < 70)
                            key = element_copy[$urandom_range(used - 1)]
                                  + (($urandom_range(1) != 0) ? 1 : -1);
                        else if (used < DEPTH && pick < 80)
                            key = element_copy[$urandom_range(DEPTH - 1, used)];
                        else if (pick < 92)
                            key = $urandom;
                        else
                            key = ($urandom_range(1) != 0) ? ELEM_MAX : ELEM_MIN;
                        offer_beat(OP_SEARCH, IDX_W'($urandom_range(DEPTH - 1)), key);
                    end
                end
            end
        end
        wait_for_quiet();
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_store();
        test_short_lists();
        test_full_store();
        test_unsorted_store();
        test_backpressure();
        test_random_traffic();
        wait_for_quiet();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_outcomes.size() != 0) begin
            $error("%0d searches never answered", awaited_outcomes.size());
            error_count++;
        end
        $display("Covered %0d stores and %0d searches (%0d hits) over %0d length settings,",
                 store_count, search_count, hit_count, length_writes);
        $display("under free flow, sender gaps, stalls, a long hold-off and an unsorted store.");
        if (error_count == 0)
            $display("multiway_sorted_search_core verification clean");
        else
            $display("multiway_sorted_search_core verification failed");
        $finish;
    end

endmodule
